### sv/gpb_pkg.sv
package gpb_pkg;

    // Field widths of the pixel, result and configuration channels.
    localparam int OP_W        = 1;
    localparam int TIDX_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 12;
    localparam int STRIDE_W    = 13;
    localparam int OUT_ADDR_W  = 24;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;

    // The upper four bits of the coverage byte select a color table entry.
    localparam int GRAY_SHIFT  = 4;
    localparam int SEL_W       = BYTE_W - GRAY_SHIFT;

    // Product of row and stride plus column, before wrapping to the address width.
    localparam int SUM_W       = COORD_W + STRIDE_W + 1;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDRESS_BITS_DEF  = 24;

    localparam logic [OP_W-1:0] OP_DRAW = 1'b0;
    localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_XOR_MODE    = 8'd3;

    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 13'd720;
    localparam logic [COORD_W-1:0]  CLIP_RIGHT_RST  = 12'd719;
    localparam logic [COORD_W-1:0]  CLIP_BOTTOM_RST = 12'd575;

    typedef struct packed {
        logic [STRIDE_W-1:0] line_stride;
        logic [COORD_W-1:0]  clip_right;
        logic [COORD_W-1:0]  clip_bottom;
        logic                xor_mode;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TIDX_W-1:0]  table_index;
        logic [BYTE_W-1:0]  table_value;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [BYTE_W-1:0]  gray_level;
        logic [BYTE_W-1:0]  old_pixel;
    } t_pix;

    typedef struct packed {
        logic                  write_enable;
        logic [OUT_ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0]     write_data;
    } t_res;

endpackage

### sv/gpb_cfg_if.sv
interface gpb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gpb_pkg::CFG_INDEX_W-1:0]   index;
    logic [gpb_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/gpb_in_if.sv
interface gpb_in_if;
    logic                          valid;
    logic                          ready;
    logic [gpb_pkg::OP_W-1:0]      op;
    logic [gpb_pkg::TIDX_W-1:0]    table_index;
    logic [gpb_pkg::BYTE_W-1:0]    table_value;
    logic [gpb_pkg::COORD_W-1:0]   pixel_x;
    logic [gpb_pkg::COORD_W-1:0]   pixel_y;
    logic [gpb_pkg::BYTE_W-1:0]    gray_level;
    logic [gpb_pkg::BYTE_W-1:0]    old_pixel;

    modport source (output valid, output op, output table_index, output table_value,
                    output pixel_x, output pixel_y, output gray_level, output old_pixel,
                    input ready);
    modport sink   (input valid, input op, input table_index, input table_value,
                    input pixel_x, input pixel_y, input gray_level, input old_pixel,
                    output ready);
endinterface

### sv/gpb_out_if.sv
interface gpb_out_if;
    logic                            valid;
    logic                            ready;
    logic                            write_enable;
    logic [gpb_pkg::OUT_ADDR_W-1:0]  write_address;
    logic [gpb_pkg::BYTE_W-1:0]      write_data;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_data, output ready);
endinterface

### sv/gpb_cfg_regs.sv
module gpb_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpb_cfg_if.sink       i_cfg,
    output gpb_pkg::t_cfg o_cfg
);

    gpb_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_stride <= gpb_pkg::LINE_STRIDE_RST;
            r_cfg.clip_right  <= gpb_pkg::CLIP_RIGHT_RST;
            r_cfg.clip_bottom <= gpb_pkg::CLIP_BOTTOM_RST;
            r_cfg.xor_mode    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gpb_pkg::REG_LINE_STRIDE: begin
                    r_cfg.line_stride <= i_cfg.data[gpb_pkg::STRIDE_W-1:0];
                end
                gpb_pkg::REG_CLIP_RIGHT: begin
                    r_cfg.clip_right <= i_cfg.data[gpb_pkg::COORD_W-1:0];
                end
                gpb_pkg::REG_CLIP_BOTTOM: begin
                    r_cfg.clip_bottom <= i_cfg.data[gpb_pkg::COORD_W-1:0];
                end
                gpb_pkg::REG_XOR_MODE: begin
                    r_cfg.xor_mode <= i_cfg.data[0];
                end
                default: begin
                    // Writes to unknown registers are ignored.
                end
            endcase
        end
    end

endmodule

### sv/gpb_color_table.sv
module gpb_color_table #(
    parameter int TABLE_ENTRIES = gpb_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [gpb_pkg::TIDX_W-1:0]   i_wr_index,
    input  logic [gpb_pkg::BYTE_W-1:0]   i_wr_data,
    input  logic [gpb_pkg::SEL_W-1:0]    i_rd_index,
    output logic [gpb_pkg::BYTE_W-1:0]   o_rd_data
);

    // A 4-bit index reaches at most 16 entries, so only those are stored.
    localparam int REACH = 1 << gpb_pkg::TIDX_W;
    localparam int SLOTS = (TABLE_ENTRIES < REACH) ? TABLE_ENTRIES : REACH;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [gpb_pkg::BYTE_W-1:0] r_table [SLOTS];
    logic                       wr_hit;
    logic                       rd_hit;
    logic [IDX_W-1:0]           wr_slot;
    logic [IDX_W-1:0]           rd_slot;

    // Indexes at or beyond the table size never store and read as zero.
    assign wr_hit  = 32'(i_wr_index) < 32'(SLOTS);
    assign rd_hit  = 32'(i_rd_index) < 32'(SLOTS);
    assign wr_slot = IDX_W'(i_wr_index);
    assign rd_slot = IDX_W'(i_rd_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_table[i] <= '0;
            end
        end else if (i_wr_en && wr_hit) begin
            r_table[wr_slot] <= i_wr_data;
        end
    end

    assign o_rd_data = rd_hit ? r_table[rd_slot] : '0;

endmodule

### sv/gpb_draw_unit.sv
module gpb_draw_unit #(
    parameter int ADDRESS_BITS = gpb_pkg::ADDRESS_BITS_DEF
) (
    input  gpb_pkg::t_pix                i_pix,
    input  gpb_pkg::t_cfg                i_cfg,
    output logic [gpb_pkg::SEL_W-1:0]    o_sel,
    input  logic [gpb_pkg::BYTE_W-1:0]   i_color,
    output gpb_pkg::t_res                o_res
);

    localparam int SUM_W = gpb_pkg::SUM_W;
    localparam logic [SUM_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= SUM_W) ? {SUM_W{1'b1}} : SUM_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    logic             in_clip;
    logic             is_draw;
    logic [SUM_W-1:0] addr_sum;
    logic [SUM_W-1:0] addr_wrap;
    logic             we;
    logic [gpb_pkg::BYTE_W-1:0] data;

    assign o_sel   = i_pix.gray_level[gpb_pkg::BYTE_W-1:gpb_pkg::GRAY_SHIFT];
    assign is_draw = i_pix.op == gpb_pkg::OP_DRAW;
    assign in_clip = (i_pix.pixel_x <= i_cfg.clip_right) && (i_pix.pixel_y <= i_cfg.clip_bottom);

    assign addr_sum  = SUM_W'(i_pix.pixel_y) * SUM_W'(i_cfg.line_stride)
                     + SUM_W'(i_pix.pixel_x);
    assign addr_wrap = addr_sum & ADDR_MASK;

    always_comb begin
        we   = 1'b0;
        data = '0;
        if (is_draw && in_clip) begin
            if (i_cfg.xor_mode) begin
                we   = 1'b1;
                data = i_pix.old_pixel ^ i_pix.gray_level;
            end else if (o_sel != '0) begin
                we   = 1'b1;
                data = i_color;
            end
        end
    end

    assign o_res.write_enable  = we;
    assign o_res.write_address = we ? addr_wrap[gpb_pkg::OUT_ADDR_W-1:0] : '0;
    assign o_res.write_data    = data;

endmodule

### sv/glyph_pixel_blit_top.sv
// Glyph pixel blitter for an 8-bit framebuffer.
// i_pix carries one transaction per glyph pixel (op draw) or per color table
// load (op load). Every transaction gives exactly one transaction on o_wr:
// write_enable with the byte address (row times stride plus column) and the
// new byte, or all zeros for loads, clipped pixels and transparent pixels.
// i_cfg writes the stride, clip bounds and XOR mode; it is always ready and
// should only be used while no pixels are in flight.
// From input acceptance to o_wr.valid there is one input register, then the
// clip test, 13x12 address multiply and palette lookup in one combinational
// pass into the output register. Throughput is one pixel per clock while
// o_wr is ready. When o_wr stalls, both registers hold and i_pix.ready drops
// only once the input register is also full.
// Reset restores the default configuration (stride 720, clip 719/575,
// palette mode), clears the color table and empties the pipeline.
module glyph_pixel_blit_top #(
    parameter int TABLE_ENTRIES = gpb_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = gpb_pkg::ADDRESS_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpb_cfg_if.sink   i_cfg,
    gpb_in_if.sink    i_pix,
    gpb_out_if.source o_wr
);

    gpb_pkg::t_cfg cfg;
    gpb_pkg::t_pix in_pix;
    gpb_pkg::t_pix r_s1;
    logic          r_s1_valid;
    gpb_pkg::t_res res;
    gpb_pkg::t_res r_out;
    logic          r_out_valid;
    logic          s1_adv;
    logic          in_acc;
    logic          tbl_we;
    logic [gpb_pkg::SEL_W-1:0]  sel;
    logic [gpb_pkg::BYTE_W-1:0] color;

    assign in_pix.op          = i_pix.op;
    assign in_pix.table_index = i_pix.table_index;
    assign in_pix.table_value = i_pix.table_value;
    assign in_pix.pixel_x     = i_pix.pixel_x;
    assign in_pix.pixel_y     = i_pix.pixel_y;
    assign in_pix.gray_level  = i_pix.gray_level;
    assign in_pix.old_pixel   = i_pix.old_pixel;

    assign s1_adv      = !r_out_valid || o_wr.ready;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // Table loads take effect as the item leaves the input register, so later
    // draws see them and earlier draws do not.
    assign tbl_we = r_s1_valid && s1_adv && (r_s1.op == gpb_pkg::OP_LOAD);

    gpb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    gpb_color_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (tbl_we),
        .i_wr_index (r_s1.table_index),
        .i_wr_data  (r_s1.table_value),
        .i_rd_index (sel),
        .o_rd_data  (color)
    );

    gpb_draw_unit #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_draw (
        .i_pix   (r_s1),
        .i_cfg   (cfg),
        .o_sel   (sel),
        .i_color (color),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= in_pix;
        end
        if (s1_adv && r_s1_valid) begin
            r_out <= res;
        end
    end

    assign o_wr.valid         = r_out_valid;
    assign o_wr.write_enable  = r_out.write_enable;
    assign o_wr.write_address = r_out.write_address;
    assign o_wr.write_data    = r_out.write_data;

endmodule
